// File: sv/md5_stream_hasher_unit_assert.svh
// Assertion macros for the MD5 stream hasher.
`ifndef MD5_STREAM_HASHER_UNIT_ASSERT_SVH
`define MD5_STREAM_HASHER_UNIT_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define MD5_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define MD5_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

// File: sv/md5sh_pkg.sv
// Package with types, constants and round tables for the MD5 stream hasher.
package md5sh_pkg;
	localparam int unsigned QueueDepth = 2;
	localparam logic [31:0] InitA = 32'h67452301;
	localparam logic [31:0] InitB = 32'hefcdab89;
	localparam logic [31:0] InitC = 32'h98badcfe;
	localparam logic [31:0] InitD = 32'h10325476;
	localparam logic [7:0] PadByte = 8'h80;

	// Item as classified by the front end.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} md5sh_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} md5sh_state_t;

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k [64];
		k = '{
			32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
			32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
			32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
			32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
			32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
			32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
			32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
			32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
			32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
			32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
			32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
			32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
			32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
			32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
			32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
			32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
		};
		return k[i];
	endfunction

	function automatic logic [4:0] rot_amount(input logic [3:0] sel);
		logic [4:0] r [16];
		r = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
			5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
		return r[sel];
	endfunction

	// Message word index used by a given round.
	function automatic logic [3:0] word_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0: g = i[3:0];
			2'd1: g = 4'(5 * i[3:0] + 1);
			2'd2: g = 4'(3 * i[3:0] + 5);
			2'd3: g = 4'(7 * i[3:0]);
			default: g = i[3:0];
		endcase
		return g;
	endfunction
endpackage

// File: sv/md5sh_front.sv
// Front end: input item queue between the stream port and the compression engine.
module md5sh_front #(
	parameter int unsigned DEPTH = md5sh_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  md5sh_pkg::md5sh_item_t in_item,
	output logic                 q_valid,
	input  logic                 q_pop,
	output md5sh_pkg::md5sh_item_t q_item
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	md5sh_pkg::md5sh_item_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	// Items with neither byte nor end do nothing and are dropped here.
	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign push = in_valid && in_ready && (in_item.has_byte || in_item.end_of_message);
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: sv/md5sh_back.sv
// Back end: block buffer, padding sequencer and one-round-per-cycle MD5 engine.
module md5sh_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  md5sh_pkg::md5sh_item_t q_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [127:0]           out_digest,
	output logic                   busy
);
	md5sh_pkg::md5sh_state_t state_q, state_d;
	logic [31:0] words_q [16];
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [5:0] rnd_q;
	logic [60:0] total_q;
	logic fin_q;
	logic [5:0] pos_q;
	logic len_only_q;
	logic [127:0] dig_q;
	logic ovalid_q;

	// Round datapath.
	logic [31:0] f, t, rot, bnew;
	logic [4:0] s;
	always_comb begin
		case (rnd_q[5:4])
			2'd0: f = (b_q & c_q) | (~b_q & d_q);
			2'd1: f = (b_q & d_q) | (c_q & ~d_q);
			2'd2: f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		t = a_q + f + words_q[md5sh_pkg::word_index(rnd_q)] + md5sh_pkg::round_const(rnd_q);
		s = md5sh_pkg::rot_amount({rnd_q[5:4], rnd_q[1:0]});
		rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
		bnew = b_q + rot;
	end

	logic [63:0] bits;
	assign bits = {total_q, 3'b000};
	assign out_valid = ovalid_q;
	assign out_digest = dig_q;
	assign busy = (state_q != md5sh_pkg::ST_IDLE) || ovalid_q;

	// Next state and queue pop.
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		case (state_q)
			md5sh_pkg::ST_IDLE: begin
				if (q_valid && !ovalid_q) begin
					q_pop = 1'b1;
					if (q_item.has_byte && total_q[5:0] == 6'd63) begin
						state_d = md5sh_pkg::ST_ROUND;
					end else if (q_item.end_of_message) begin
						state_d = md5sh_pkg::ST_PAD;
					end
				end
			end
			md5sh_pkg::ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = md5sh_pkg::ST_ADD;
				end
			end
			md5sh_pkg::ST_ADD: begin
				if (!fin_q) begin
					state_d = md5sh_pkg::ST_IDLE;
				end else if (pos_q == 6'd0) begin
					state_d = md5sh_pkg::ST_PAD;
				end else begin
					state_d = md5sh_pkg::ST_OUT;
				end
			end
			md5sh_pkg::ST_PAD: begin
				state_d = md5sh_pkg::ST_LEN;
			end
			md5sh_pkg::ST_LEN: begin
				state_d = md5sh_pkg::ST_ROUND;
			end
			md5sh_pkg::ST_OUT: begin
				state_d = md5sh_pkg::ST_IDLE;
			end
			default: state_d = md5sh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= md5sh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control and payload registers. pos_q tracks padding: in ST_PAD it marks
	// the byte that gets 0x80; after padding it is zero while a length-only
	// block still follows and one once the length has been placed.
	// len_only_q marks that the next padded block holds only zeros and length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '{md5sh_pkg::InitA, md5sh_pkg::InitB, md5sh_pkg::InitC, md5sh_pkg::InitD};
			total_q <= '0;
			rnd_q <= '0;
			fin_q <= 1'b0;
			pos_q <= '0;
			len_only_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				md5sh_pkg::ST_IDLE: begin
					if (q_pop) begin
						fin_q <= q_item.end_of_message;
						if (q_item.has_byte) begin
							total_q <= total_q + 61'd1;
						end
						pos_q <= q_item.has_byte ? total_q[5:0] + 6'd1 : total_q[5:0];
						if (q_item.has_byte) begin
							words_q[total_q[5:2]][8*total_q[1:0] +: 8] <= q_item.data_byte;
						end
						a_q <= h_q[0];
						b_q <= h_q[1];
						c_q <= h_q[2];
						d_q <= h_q[3];
						rnd_q <= '0;
					end
				end
				md5sh_pkg::ST_ROUND: begin
					a_q <= d_q;
					d_q <= c_q;
					c_q <= b_q;
					b_q <= bnew;
					rnd_q <= rnd_q + 6'd1;
				end
				md5sh_pkg::ST_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					a_q <= h_q[0] + a_q;
					b_q <= h_q[1] + b_q;
					c_q <= h_q[2] + c_q;
					d_q <= h_q[3] + d_q;
				end
				md5sh_pkg::ST_PAD: begin
					// A length-only block is cleared; otherwise 0x80 goes at pos_q
					// and zeros follow it.
					for (int w = 0; w < 16; w++) begin
						for (int b = 0; b < 4; b++) begin
							if (len_only_q || 6'(4*w+b) > pos_q) begin
								words_q[w][8*b +: 8] <= 8'h00;
							end else if (6'(4*w+b) == pos_q) begin
								words_q[w][8*b +: 8] <= md5sh_pkg::PadByte;
							end
						end
					end
					if (!len_only_q && pos_q > 6'd55) begin
						pos_q <= 6'd0;
						len_only_q <= 1'b1;
					end else begin
						pos_q <= 6'd1;
						len_only_q <= 1'b0;
					end
				end
				md5sh_pkg::ST_LEN: begin
					if (pos_q != 6'd0) begin
						words_q[14] <= bits[31:0];
						words_q[15] <= bits[63:32];
					end
					a_q <= h_q[0];
					b_q <= h_q[1];
					c_q <= h_q[2];
					d_q <= h_q[3];
					rnd_q <= '0;
				end
				md5sh_pkg::ST_OUT: begin
					dig_q <= {d_q, c_q, b_q, a_q};
					ovalid_q <= 1'b1;
					h_q <= '{md5sh_pkg::InitA, md5sh_pkg::InitB, md5sh_pkg::InitC,
						md5sh_pkg::InitD};
					total_q <= '0;
					fin_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule

// File: sv/md5_stream_hasher_unit.sv
// Top level of the MD5 stream hasher: item queue plus compression back end.
//   channel | dir | tdata                                 | tuser    | tlast
//   s_axis  | in  | data_byte[7:0]                        | has_byte | end_of_message
//   m_axis  | out | digest_first_half, digest_second_half | none     | none
// A byte item leaves the queue and is written into the block buffer; the 64th byte
// of a block also starts the 64 rounds and an add step, and no item is taken meanwhile.
// End of message: a pad step, a length step, 64 rounds and an add per padded block,
// then an output step that makes the digest valid; the padding may spill into a
// second block.
// Reset clears control state and loads the MD5 initial chaining words.
// A stalled digest holds the engine; a queue of QUEUE_DEPTH entries (two by default) keeps taking items until full.
module md5_stream_hasher_unit #(
	parameter int unsigned QUEUE_DEPTH = md5sh_pkg::QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // data_byte[7:0]
	input  logic         s_axis_tuser,  // has_byte
	input  logic         s_axis_tlast,  // end_of_message
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // digest_first_half[63:0], digest_second_half
);
	`include "md5_stream_hasher_unit_assert.svh"

	md5sh_pkg::md5sh_item_t in_item, q_item;
	logic q_valid, q_pop, busy;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.has_byte = s_axis_tuser;
	assign in_item.end_of_message = s_axis_tlast;

	md5sh_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	md5sh_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_digest(m_axis_tdata), .busy(busy)
	);

	`MD5_ASSERT_IMP(a_pop_needs_item, clk, arst_n, q_pop, q_valid, "pop from empty queue")
	`MD5_ASSERT_IMP(a_valid_busy, clk, arst_n, m_axis_tvalid, busy, "digest shown while idle")
	`MD5_ASSERT_NEXT(a_digest_held, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		$stable(m_axis_tdata), "stalled digest changed")
endmodule
